/* rtl/core/dlle_pkg.sv */
// ----------------------------------------------------------------------------
// dlle_pkg
// Shared widths, codes, sequencer states and the link-table write bundle for
// the doubly linked list engine.
// ----------------------------------------------------------------------------
package dlle_pkg;

  // Field widths
  localparam int OP_W     = 3;
  localparam int HANDLE_W = 7;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 7;   // slot numbers: 0 head, 1 tail, 2.. elements

  // Default element capacity
  localparam int NODES_DEF = 64;

  // Sentinel slots
  localparam logic [SLOT_W-1:0] SLOT_HEAD = 7'd0;
  localparam logic [SLOT_W-1:0] SLOT_TAIL = 7'd1;
  localparam logic [SLOT_W-1:0] SLOT_BASE = 7'd2;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_PUSH_HEAD  = 3'd0,
    OP_PUSH_TAIL  = 3'd1,
    OP_INS_AFTER  = 3'd2,
    OP_INS_BEFORE = 3'd3,
    OP_DELETE     = 3'd4,
    OP_DUMP_FWD   = 3'd5,
    OP_DUMP_BWD   = 3'd6
  } op_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STS_OK         = 2'd0,
    STS_FULL       = 2'd1,
    STS_BAD_HANDLE = 2'd2,
    STS_EMPTY      = 2'd3
  } status_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,   // waiting for an input beat
    S_READ,   // link tables sample the referenced slot
    S_GOT,    // neighbor links available
    S_LINK1,  // write links of the new node
    S_LINK2,  // write links of the neighbors
    S_DREAD,  // dump: tables sample the current slot
    S_DOUT,   // dump: emit the current value
    S_RESP    // emit a single status beat
  } state_t;

  // One write to each link table per cycle
  typedef struct packed {
    logic              nxt_we;
    logic [SLOT_W-1:0] nxt_addr;
    logic [SLOT_W-1:0] nxt_data;
    logic              prv_we;
    logic [SLOT_W-1:0] prv_addr;
    logic [SLOT_W-1:0] prv_data;
  } link_wr_t;

endpackage

/* rtl/core/doubly_linked_list_engine.sv */
// ----------------------------------------------------------------------------
// doubly_linked_list_engine
// Doubly linked list in fixed node tables with head and tail sentinels;
// insert, delete and dump operations run under a small sequencer.
// ----------------------------------------------------------------------------
//   channel  dir  handshake            beat contents
//   in_      in   in_valid / in_stall  in_op, in_handle, in_value
//   out_     out  out_valid/ out_stall out_status, out_value, out_last
//
// One item is taken at a time: in_stall stays high until the sequencer is
//   back in idle. Its pace is set by the single read and write port of the
//   link tables and their registered read.
// Reset clears the sentinel links, live bits, node count and output valid;
// the tables themselves need no clearing pass.
// A result beat sits in an output register; a stall there holds the sequencer.
// ----------------------------------------------------------------------------
module doubly_linked_list_engine #(
  parameter int NODES = dlle_pkg::NODES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [dlle_pkg::OP_W-1:0]           in_op,
  input  logic [dlle_pkg::HANDLE_W-1:0]       in_handle,
  input  logic signed [dlle_pkg::VALUE_W-1:0] in_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [dlle_pkg::STATUS_W-1:0]       out_status,
  output logic signed [dlle_pkg::VALUE_W-1:0] out_value,
  output logic                                out_last
);
  import dlle_pkg::*;

  localparam int CNT_W  = $clog2(NODES + 1);
  localparam int VIDX_W = $clog2(NODES);

  state_t state_r, state_nxt;

  op_t                       op_r, op_nxt;
  logic [HANDLE_W-1:0]       hdl_r, hdl_nxt;
  logic signed [VALUE_W-1:0] val_r, val_nxt;
  logic [SLOT_W-1:0]         cur_r, cur_nxt;
  logic [SLOT_W-1:0]         a_r, a_nxt;
  logic [SLOT_W-1:0]         b_r, b_nxt;
  status_t                   status_r, status_nxt;

  logic [SLOT_W-1:0]         head_next_r, head_next_nxt;
  logic [SLOT_W-1:0]         tail_prev_r, tail_prev_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic [NODES-1:0]          live_r, live_nxt;

  logic                      out_valid_r, out_valid_nxt;
  status_t                   out_status_r, out_status_nxt;
  logic signed [VALUE_W-1:0] out_value_r, out_value_nxt;
  logic                      out_last_r, out_last_nxt;

  link_wr_t                  wr;
  logic                      val_we;
  logic [SLOT_W-1:0]         rd_next, rd_prev;
  logic signed [VALUE_W-1:0] rd_value;

  op_t                       in_opc;
  logic                      full;
  logic                      hok;
  logic [HANDLE_W-1:0]       in_lofs;
  logic [HANDLE_W-1:0]       hdl_lofs;
  logic [SLOT_W-1:0]         new_id;
  logic                      out_free;
  logic                      fwd;
  logic [SLOT_W-1:0]         step;
  logic                      dump_end;

  // --------------------------------------------------------------------------
  // Shared decode
  // --------------------------------------------------------------------------
  assign in_opc   = op_t'(in_op);
  assign full     = (cnt_r == CNT_W'(NODES));
  assign in_lofs  = in_handle - HANDLE_W'(1);
  assign hok      = (in_handle != '0) && (in_handle <= HANDLE_W'(cnt_r)) &&
                    live_r[in_lofs[VIDX_W-1:0]];
  assign hdl_lofs = hdl_r - HANDLE_W'(1);
  assign new_id   = SLOT_W'(cnt_r) + SLOT_BASE;
  assign out_free = !out_valid_r || !out_stall;
  assign fwd      = (op_r == OP_DUMP_FWD);
  assign step     = fwd ? rd_next : rd_prev;
  assign dump_end = fwd ? (step == SLOT_TAIL) : (step == SLOT_HEAD);

  // --------------------------------------------------------------------------
  // Tables
  // --------------------------------------------------------------------------
  dlle_link_store #(
    .NODES (NODES)
  ) u_store (
    .clk      (clk),
    .wr       (wr),
    .val_we   (val_we),
    .val_slot (new_id),
    .val_data (val_r),
    .rd_slot  (cur_r),
    .rd_next  (rd_next),
    .rd_prev  (rd_prev),
    .rd_value (rd_value)
  );

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_opc)
            OP_PUSH_HEAD, OP_PUSH_TAIL: begin
              state_nxt = full ? S_RESP : S_LINK1;
            end
            OP_INS_AFTER, OP_INS_BEFORE: begin
              state_nxt = (full || !hok) ? S_RESP : S_READ;
            end
            OP_DELETE: begin
              state_nxt = hok ? S_READ : S_RESP;
            end
            OP_DUMP_FWD: begin
              state_nxt = (head_next_r == SLOT_TAIL) ? S_RESP : S_DREAD;
            end
            OP_DUMP_BWD: begin
              state_nxt = (tail_prev_r == SLOT_HEAD) ? S_RESP : S_DREAD;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_READ:  state_nxt = S_GOT;
      S_GOT:   state_nxt = (op_r == OP_DELETE) ? S_RESP : S_LINK1;
      S_LINK1: state_nxt = S_LINK2;
      S_LINK2: state_nxt = S_RESP;
      S_DREAD: state_nxt = S_DOUT;
      S_DOUT: begin
        if (out_free) begin
          state_nxt = dump_end ? S_IDLE : S_DREAD;
        end
      end
      S_RESP: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath and outputs
  // --------------------------------------------------------------------------
  always_comb begin
    op_nxt         = op_r;
    hdl_nxt        = hdl_r;
    val_nxt        = val_r;
    cur_nxt        = cur_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    status_nxt     = status_r;
    head_next_nxt  = head_next_r;
    tail_prev_nxt  = tail_prev_r;
    cnt_nxt        = cnt_r;
    live_nxt       = live_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_last_nxt   = out_last_r;
    wr             = '0;
    val_we         = 1'b0;
    in_stall       = (state_r != S_IDLE);

    case (state_r)
      // latch the beat and settle checks
      S_IDLE: begin
        if (in_valid) begin
          op_nxt     = in_opc;
          hdl_nxt    = in_handle;
          val_nxt    = in_value;
          cur_nxt    = in_handle + HANDLE_W'(1);
          status_nxt = STS_OK;
          case (in_opc)
            OP_PUSH_HEAD: begin
              a_nxt      = SLOT_HEAD;
              b_nxt      = head_next_r;
              status_nxt = full ? STS_FULL : STS_OK;
            end
            OP_PUSH_TAIL: begin
              a_nxt      = tail_prev_r;
              b_nxt      = SLOT_TAIL;
              status_nxt = full ? STS_FULL : STS_OK;
            end
            OP_INS_AFTER, OP_INS_BEFORE: begin
              if (full) begin
                status_nxt = STS_FULL;
              end else if (!hok) begin
                status_nxt = STS_BAD_HANDLE;
              end
            end
            OP_DELETE: begin
              status_nxt = hok ? STS_OK : STS_BAD_HANDLE;
            end
            OP_DUMP_FWD: begin
              cur_nxt    = head_next_r;
              status_nxt = (head_next_r == SLOT_TAIL) ? STS_EMPTY : STS_OK;
            end
            OP_DUMP_BWD: begin
              cur_nxt    = tail_prev_r;
              status_nxt = (tail_prev_r == SLOT_HEAD) ? STS_EMPTY : STS_OK;
            end
            default: begin
              status_nxt = status_r;
            end
          endcase
        end
      end

      // neighbors of the referenced slot are in
      S_GOT: begin
        case (op_r)
          OP_INS_AFTER: begin
            a_nxt = cur_r;
            b_nxt = rd_next;
          end
          OP_INS_BEFORE: begin
            a_nxt = rd_prev;
            b_nxt = cur_r;
          end
          default: begin
            // unlink: prev -> next
            if (rd_prev == SLOT_HEAD) begin
              head_next_nxt = rd_next;
            end else begin
              wr.nxt_we   = 1'b1;
              wr.nxt_addr = rd_prev;
              wr.nxt_data = rd_next;
            end
            if (rd_next == SLOT_TAIL) begin
              tail_prev_nxt = rd_prev;
            end else begin
              wr.prv_we   = 1'b1;
              wr.prv_addr = rd_next;
              wr.prv_data = rd_prev;
            end
            live_nxt[hdl_lofs[VIDX_W-1:0]] = 1'b0;
          end
        endcase
      end

      // new node: its own links, value and live bit
      S_LINK1: begin
        wr.nxt_we   = 1'b1;
        wr.nxt_addr = new_id;
        wr.nxt_data = b_r;
        wr.prv_we   = 1'b1;
        wr.prv_addr = new_id;
        wr.prv_data = a_r;
        val_we      = 1'b1;
        live_nxt[cnt_r[VIDX_W-1:0]] = 1'b1;
      end

      // neighbors point at the new node
      S_LINK2: begin
        if (a_r == SLOT_HEAD) begin
          head_next_nxt = new_id;
        end else begin
          wr.nxt_we   = 1'b1;
          wr.nxt_addr = a_r;
          wr.nxt_data = new_id;
        end
        if (b_r == SLOT_TAIL) begin
          tail_prev_nxt = new_id;
        end else begin
          wr.prv_we   = 1'b1;
          wr.prv_addr = b_r;
          wr.prv_data = new_id;
        end
        cnt_nxt = cnt_r + CNT_W'(1);
      end

      // one dump beat per element
      S_DOUT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STS_OK;
          out_value_nxt  = rd_value;
          out_last_nxt   = dump_end;
          cur_nxt        = step;
        end
      end

      // single status beat
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_value_nxt  = '0;
          out_last_nxt   = 1'b1;
        end
      end

      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_next_r <= SLOT_TAIL;
      tail_prev_r <= SLOT_HEAD;
      cnt_r       <= '0;
      live_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_next_r <= head_next_nxt;
      tail_prev_r <= tail_prev_nxt;
      cnt_r       <= cnt_nxt;
      live_r      <= live_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    hdl_r        <= hdl_nxt;
    val_r        <= val_nxt;
    cur_r        <= cur_nxt;
    a_r          <= a_nxt;
    b_r          <= b_nxt;
    status_r     <= status_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_value  = out_value_r;
  assign out_last   = out_last_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(NODES))
    else $error("node count above capacity");

  a_empty_agree: assert property (@(posedge clk) disable iff (!rst_n)
    (head_next_r == SLOT_TAIL) == (tail_prev_r == SLOT_HEAD))
    else $error("head and tail sentinels disagree on empty list");

  a_no_self_link: assert property (@(posedge clk) disable iff (!rst_n)
    (head_next_r != SLOT_HEAD) && (tail_prev_r != SLOT_TAIL))
    else $error("sentinel links to itself");

  a_cnt_on_link2: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != $past(cnt_r)) |-> ($past(state_r) == S_LINK2))
    else $error("node count moved outside the link step");

  a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP && out_free) |=> (state_r == S_IDLE && out_valid_r && out_last_r))
    else $error("status beat not marked last");

endmodule

/* rtl/core/dlle_link_store.sv */
// ----------------------------------------------------------------------------
// dlle_link_store
// Next-link, prev-link and value tables. One write port per table, one read
// address shared by all three, read data registered.
// ----------------------------------------------------------------------------
module dlle_link_store #(
  parameter int NODES = dlle_pkg::NODES_DEF
) (
  input  logic                              clk,
  input  dlle_pkg::link_wr_t                wr,
  input  logic                              val_we,
  input  logic [dlle_pkg::SLOT_W-1:0]       val_slot,
  input  logic signed [dlle_pkg::VALUE_W-1:0] val_data,
  input  logic [dlle_pkg::SLOT_W-1:0]       rd_slot,
  output logic [dlle_pkg::SLOT_W-1:0]       rd_next,
  output logic [dlle_pkg::SLOT_W-1:0]       rd_prev,
  output logic signed [dlle_pkg::VALUE_W-1:0] rd_value
);
  import dlle_pkg::*;

  localparam int SLOTS  = NODES + 2;
  localparam int LIDX_W = $clog2(SLOTS);
  localparam int VIDX_W = $clog2(NODES);

  logic [SLOT_W-1:0]        next_mem [SLOTS];
  logic [SLOT_W-1:0]        prev_mem [SLOTS];
  logic signed [VALUE_W-1:0] value_mem [NODES];

  logic [SLOT_W-1:0] wr_vofs;
  logic [SLOT_W-1:0] rd_vofs;

  // element slots start after the two sentinels
  assign wr_vofs = val_slot - SLOT_BASE;
  assign rd_vofs = rd_slot - SLOT_BASE;

  // link table writes
  always_ff @(posedge clk) begin
    if (wr.nxt_we) begin
      next_mem[wr.nxt_addr[LIDX_W-1:0]] <= wr.nxt_data;
    end
    if (wr.prv_we) begin
      prev_mem[wr.prv_addr[LIDX_W-1:0]] <= wr.prv_data;
    end
  end

  // value table write
  always_ff @(posedge clk) begin
    if (val_we) begin
      value_mem[wr_vofs[VIDX_W-1:0]] <= val_data;
    end
  end

  // registered reads
  always_ff @(posedge clk) begin
    rd_next  <= next_mem[rd_slot[LIDX_W-1:0]];
    rd_prev  <= prev_mem[rd_slot[LIDX_W-1:0]];
    rd_value <= value_mem[rd_vofs[VIDX_W-1:0]];
  end

endmodule

/* test/doubly_linked_list_engine_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// doubly_linked_list_engine_test
// Self-checking bench for the linked list engine. A scoreboard class keeps a
// shadow copy of the link tables and predicts every result beat at input
// accept time. Stimulus is a short directed list followed by random list
// traffic under three idle/stall mixes, including one long output hold-off.
// ----------------------------------------------------------------------------
module doubly_linked_list_engine_test;
  import dlle_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 10;
  localparam int CAPACITY     = NODES_DEF;
  localparam int SLOTS        = CAPACITY + 2;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int LIMIT_CYCLES = 1_000_000;

  // Spare opcode, accepted and dropped by the engine
  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

  // One expected result beat
  typedef struct {
    status_t                   status;
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } list_beat_t;

  // Shadow list and queue of expected result beats
  class list_tracker;
    logic [SLOT_W-1:0]         next_slot [SLOTS];
    logic [SLOT_W-1:0]         prev_slot [SLOTS];
    logic signed [VALUE_W-1:0] elem_value [CAPACITY];
    bit                        elem_live [CAPACITY];
    int                        used_count;
    list_beat_t                pending_beats [$];
    int mismatches, beats_checked, items_seen;
    int full_hits, bad_handles, empty_dumps, longest_dump;

    function new();
      foreach (next_slot[i]) begin
        next_slot[i] = '0;
        prev_slot[i] = '0;
      end
      foreach (elem_live[i]) elem_live[i] = 1'b0;
      next_slot[SLOT_HEAD] = SLOT_TAIL;
      prev_slot[SLOT_TAIL] = SLOT_HEAD;
      used_count = 0;
    endfunction

    function void link_pair(int a, int b);
      next_slot[a] = SLOT_W'(b);
      prev_slot[b] = SLOT_W'(a);
    endfunction

    function void push_beat(status_t status, logic signed [VALUE_W-1:0] value, logic last);
      list_beat_t beat;
      beat.status = status;
      beat.value  = value;
      beat.last   = last;
      pending_beats.push_back(beat);
    endfunction

    function bit handle_live(logic [HANDLE_W-1:0] h);
      if (h == 0 || h > used_count || h > CAPACITY) return 1'b0;
      return elem_live[h - 1];
    endfunction

    function logic [HANDLE_W-1:0] pick_live_handle();
      int live_ids [$];
      for (int i = 0; i < used_count; i++)
        if (elem_live[i]) live_ids.push_back(i + 1);
      if (live_ids.size() == 0) return '0;
      return HANDLE_W'(live_ids[$urandom_range(0, live_ids.size() - 1)]);
    endfunction

    // Predict the result beats of one accepted input beat
    function void apply_op(logic [OP_W-1:0] op, logic [HANDLE_W-1:0] h,
                           logic signed [VALUE_W-1:0] v);
      int  slot, anchor, cur, stop, count;
      bit  fwd;
      items_seen++;
      anchor = h + 1;
      case (op)
        OP_PUSH_HEAD, OP_PUSH_TAIL, OP_INS_AFTER, OP_INS_BEFORE: begin
          // capacity is checked ahead of the anchor handle
          if (used_count >= CAPACITY) begin
            full_hits++;
            push_beat(STS_FULL, '0, 1'b1);
            return;
          end
          if ((op == OP_INS_AFTER || op == OP_INS_BEFORE) && !handle_live(h)) begin
            bad_handles++;
            push_beat(STS_BAD_HANDLE, '0, 1'b1);
            return;
          end
          slot = used_count + SLOT_BASE;
          elem_value[used_count] = v;
          elem_live[used_count]  = 1'b1;
          used_count++;
          case (op)
            OP_PUSH_HEAD: begin
              link_pair(slot, next_slot[SLOT_HEAD]);
              link_pair(SLOT_HEAD, slot);
            end
            OP_PUSH_TAIL: begin
              link_pair(prev_slot[SLOT_TAIL], slot);
              link_pair(slot, SLOT_TAIL);
            end
            OP_INS_AFTER: begin
              link_pair(slot, next_slot[anchor]);
              link_pair(anchor, slot);
            end
            default: begin
              link_pair(prev_slot[anchor], slot);
              link_pair(slot, anchor);
            end
          endcase
          push_beat(STS_OK, '0, 1'b1);
        end
        OP_DELETE: begin
          if (!handle_live(h)) begin
            bad_handles++;
            push_beat(STS_BAD_HANDLE, '0, 1'b1);
            return;
          end
          link_pair(prev_slot[anchor], next_slot[anchor]);
          elem_live[h - 1] = 1'b0;
          push_beat(STS_OK, '0, 1'b1);
        end
        OP_DUMP_FWD, OP_DUMP_BWD: begin
          fwd   = (op == OP_DUMP_FWD);
          stop  = fwd ? SLOT_TAIL : SLOT_HEAD;
          cur   = fwd ? next_slot[SLOT_HEAD] : prev_slot[SLOT_TAIL];
          count = 0;
          while (cur != stop && cur >= SLOT_BASE && cur < SLOTS && count < CAPACITY) begin
            push_beat(STS_OK, elem_value[cur - SLOT_BASE], 1'b0);
            cur = fwd ? next_slot[cur] : prev_slot[cur];
            count++;
          end
          if (count == 0) begin
            empty_dumps++;
            push_beat(STS_EMPTY, '0, 1'b1);
          end else begin
            pending_beats[pending_beats.size() - 1].last = 1'b1;
            if (count > longest_dump) longest_dump = count;
          end
        end
        default: ;  // spare opcode: no result
      endcase
    endfunction

    // Compare one accepted result beat against the oldest prediction
    function void check_beat(logic [STATUS_W-1:0] status,
                             logic signed [VALUE_W-1:0] value, logic last);
      list_beat_t want;
      beats_checked++;
      if (pending_beats.size() == 0) begin
        $error("unexpected result beat: status %0d value %0d last %0d",
               status, value, last);
        mismatches++;
        return;
      end
      want = pending_beats.pop_front();
      if (status !== want.status) begin
        $error("out_status: expected %0d, got %0d", want.status, status);
        mismatches++;
      end
      if (value !== want.value) begin
        $error("out_value: expected %0d, got %0d", want.value, value);
        mismatches++;
      end
      if (last !== want.last) begin
        $error("out_last: expected %0d, got %0d", want.last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic                      clk        = 1'b0;
  logic                      rst_n      = 1'b0;
  logic                      in_valid   = 1'b0;
  logic                      in_stall;
  logic [OP_W-1:0]           in_op      = '0;
  logic [HANDLE_W-1:0]       in_handle  = '0;
  logic signed [VALUE_W-1:0] in_value   = '0;
  logic                      out_valid;
  logic                      out_stall  = 1'b0;
  logic [STATUS_W-1:0]       out_status;
  logic signed [VALUE_W-1:0] out_value;
  logic                      out_last;

  int  sender_idle_pct    = 0;
  int  receiver_stall_pct = 0;
  bit  hold_toggle        = 1'b0;
  bit  hold_seen          = 1'b0;
  int  hold_left          = 0;

  list_tracker tracker = new();

  doubly_linked_list_engine #(
    .NODES (CAPACITY)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_op      (in_op),
    .in_handle  (in_handle),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_status (out_status),
    .out_value  (out_value),
    .out_last   (out_last)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Result side: check accepted beats, then pick next cycle's stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      tracker.check_beat(out_status, out_value, out_last);
    if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
    end
  end

  // Drive one input beat and wait for it to be taken
  task automatic send_beat(input logic [OP_W-1:0] op, input logic [HANDLE_W-1:0] handle,
                           input logic signed [VALUE_W-1:0] value);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_op     <= op;
    in_handle <= handle;
    in_value  <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.apply_op(op, handle, value);
  endtask

  function automatic logic signed [VALUE_W-1:0] random_value();
    case ($urandom_range(0, 7))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // Random list traffic: mostly valid handles, some noise and spare opcodes
  task automatic run_random(input int item_count, input int send_idle,
                            input int recv_stall, input bit long_hold);
    int                  done;
    int                  pick;
    logic [OP_W-1:0]     op;
    logic [HANDLE_W-1:0] handle;
    sender_idle_pct    = send_idle;
    receiver_stall_pct = recv_stall;
    if (long_hold) hold_toggle <= ~hold_toggle;
    done = 0;
    while (done < item_count) begin
      pick   = $urandom_range(0, 99);
      handle = HANDLE_W'($urandom_range(0, 127));
      if (pick < 40) begin
        op = OP_W'($urandom_range(OP_PUSH_HEAD, OP_INS_BEFORE));
        if ((op == OP_INS_AFTER || op == OP_INS_BEFORE) && $urandom_range(0, 9) != 0)
          handle = tracker.pick_live_handle();
      end else if (pick < 65) begin
        op = OP_DELETE;
        if ($urandom_range(0, 9) != 0) handle = tracker.pick_live_handle();
      end else if (pick < 85) begin
        op = OP_W'($urandom_range(OP_DUMP_FWD, OP_DUMP_BWD));
      end else if (pick < 90) begin
        op = OP_UNUSED;
      end else begin
        // raw handle, mostly dead or never allocated
        op = OP_W'($urandom_range(OP_INS_AFTER, OP_DELETE));
      end
      send_beat(op, handle, random_value());
      if (op != OP_UNUSED) done++;
    end
  endtask

  // Run watchdog
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("doubly_linked_list_engine regression: fail");
    $finish;
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty list, bad handles, edge inserts, deletes, dumps
    send_beat(OP_DUMP_FWD, 7'd127, -32'sd1);
    send_beat(OP_DUMP_BWD, 7'd0, 32'sh7fff_ffff);
    send_beat(OP_DELETE, 7'd1, 32'sh8000_0000);
    send_beat(OP_INS_AFTER, 7'd0, 32'sd5);
    send_beat(OP_PUSH_HEAD, 7'd127, 32'sh7fff_ffff);     // handle 1
    send_beat(OP_PUSH_TAIL, 7'd64, 32'sh8000_0000);      // handle 2
    send_beat(OP_PUSH_HEAD, 7'd0, 32'sd0);               // handle 3
    send_beat(OP_INS_AFTER, 7'd1, -32'sd1);              // handle 4
    send_beat(OP_INS_BEFORE, 7'd2, 32'sh5a5a_a5a5);      // handle 5
    send_beat(OP_INS_BEFORE, 7'd3, 32'sd17);             // handle 6, new first
    send_beat(OP_INS_AFTER, 7'd2, -32'sd17);             // handle 7, new last
    send_beat(OP_DUMP_FWD, 7'd127, -32'sd1);
    send_beat(OP_DUMP_BWD, 7'd85, 32'sh2aaa_5555);
    send_beat(OP_UNUSED, 7'd127, -32'sd1);
    send_beat(OP_DELETE, 7'd6, 32'sd0);
    send_beat(OP_DELETE, 7'd7, -32'sd1);
    send_beat(OP_DELETE, 7'd6, 32'sd0);                  // already deleted
    send_beat(OP_INS_BEFORE, 7'd6, 32'sd9);              // dead anchor
    send_beat(OP_DELETE, 7'd64, 32'sd0);                 // never allocated
    send_beat(OP_DUMP_FWD, 7'd0, 32'sd0);
    for (int h = 1; h <= 5; h++) send_beat(OP_DELETE, HANDLE_W'(h), 32'sd0);
    send_beat(OP_DUMP_BWD, 7'd42, 32'sd0);

    // Random traffic under three idle mixes; long output hold in the second
    run_random(115, 25, 46, 1'b0);
    run_random(115, 46, 25, 1'b1);
    run_random(110, 0, 0, 1'b0);
    in_valid <= 1'b0;

    while (tracker.pending_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d input beats, %0d result beats, longest dump %0d elements",
             tracker.items_seen, tracker.beats_checked, tracker.longest_dump);
    $display("store-full rejects %0d, bad handles %0d, empty dumps %0d, mismatches %0d",
             tracker.full_hits, tracker.bad_handles, tracker.empty_dumps,
             tracker.mismatches);
    if (tracker.mismatches == 0)
      $display("doubly_linked_list_engine regression: pass");
    else
      $display("doubly_linked_list_engine regression: fail");
    $finish;
  end

endmodule

/* sim.f */
rtl/core/dlle_pkg.sv
rtl/core/dlle_link_store.sv
rtl/core/doubly_linked_list_engine.sv
test/doubly_linked_list_engine_test.sv
